### hw/rtl/qsed_pkg.sv
package qsed_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] TERM_RESET = 8'd34;
  localparam logic [7:0] CH_BSLASH  = 8'h5c;
  localparam logic [7:0] CH_CARET   = 8'h5e;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CTRL_MASK  = 8'h1f;
  localparam logic [1:0] DIGITS_MAX = 2'd3;

  typedef enum logic [2:0] {
    MODE_PLAIN  = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_CARET  = 3'd2,
    MODE_DIGITS = 3'd3
  } mode_t;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       token_end;
    logic       run_last;
  } res_t;

  // escape letter translation, other bytes pass unchanged
  function automatic logic [7:0] esc_lookup(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    case (c)
      8'h72, 8'h52: r = 8'd13;  // r
      8'h6e, 8'h4e: r = 8'd10;  // n
      8'h66, 8'h46: r = 8'd12;  // f
      8'h74, 8'h54: r = 8'd9;   // t
      8'h62, 8'h42: r = 8'd8;   // b
      8'h76, 8'h56: r = 8'd11;  // v
      8'h3f:        r = 8'd127; // ?
      8'h65, 8'h45: r = 8'd27;  // e
      default:      r = c;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/quoted_string_escape_decoder_top.sv
// results of an accepted beat are written into the result queue, which drives m_* from its head
// throughput: one input beat per cycle while s_tready is high, results drain at one per cycle while
//   m_tready is high; a byte that ends a short digit run makes two results, the output queue absorbs the extra
// s_tready drops only while the 4-entry result queue has fewer than two free slots
// reset (rst, synchronous, active high): plain mode, digit state cleared, queue empty,
//   terminator back to 34 (double quote)
module quoted_string_escape_decoder_top (
  input  logic       clk,
  input  logic       rst,
  // configuration: terminator byte
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  // raw body bytes
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  // decoded results
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,   // run_last
  output logic       m_tuser    // [0] token_end
);
  import qsed_pkg::*;

  logic [7:0]        terminator;
  mode_t             mode, mode_next;
  logic [7:0]        octal_value, octal_value_next;
  logic [1:0]        octal_count, octal_count_next;

  // result queue
  res_t              q [QDEPTH];
  logic [QPTR_W-1:0] head, tail;
  logic [QCNT_W-1:0] count;

  logic              in_acc, out_acc;
  logic [1:0]        n_res;
  res_t              r0, r1;
  logic              is_digit;
  logic [7:0]        digit_val;
  logic [1:0]        count_inc;

  // config is taken at any time; the user must write it only while idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      terminator <= TERM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      terminator <= cfg_data;
    end
  end

  // room for the worst case of two results
  assign s_tready = (count <= QCNT_W'(QDEPTH - 2));
  assign in_acc   = s_tvalid && s_tready;
  assign out_acc  = m_tvalid && m_tready;

  assign is_digit  = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
  // '0'..'9' carry their value in the low nibble
  assign digit_val = {4'b0, s_tdata[3:0]};
  assign count_inc = octal_count + 2'd1;

  // decode of one byte against the current mode
  always_comb begin
    mode_next        = mode;
    octal_value_next = octal_value;
    octal_count_next = octal_count;
    n_res            = 2'd0;
    r0               = '0;
    r1               = '0;
    unique case (mode)
      MODE_ESC: begin
        if (is_digit) begin
          octal_value_next = digit_val;
          octal_count_next = 2'd1;
          mode_next        = MODE_DIGITS;
        end else if (s_tdata == CH_CARET) begin
          mode_next = MODE_CARET;
        end else begin
          mode_next = MODE_PLAIN;
          n_res     = 2'd1;
          r0        = '{byte_val: esc_lookup(s_tdata), token_end: 1'b0, run_last: 1'b1};
        end
      end
      MODE_CARET: begin
        mode_next = MODE_PLAIN;
        n_res     = 2'd1;
        r0        = '{byte_val: s_tdata & CTRL_MASK, token_end: 1'b0, run_last: 1'b1};
      end
      MODE_DIGITS: begin
        if (is_digit) begin
          octal_value_next = {octal_value[4:0], 3'b000} + digit_val;
          octal_count_next = count_inc;
          // third digit closes the run at once
          if (count_inc == DIGITS_MAX || count_inc == 2'd0) begin
            n_res            = 2'd1;
            r0               = '{byte_val: octal_value_next, token_end: 1'b0,
                                 run_last: 1'b1};
            mode_next        = MODE_PLAIN;
            octal_value_next = '0;
            octal_count_next = '0;
          end
        end else begin
          // short run: flush its value, then treat the byte as plain text
          octal_value_next = '0;
          octal_count_next = '0;
          mode_next        = MODE_PLAIN;
          r0               = '{byte_val: octal_value, token_end: 1'b0, run_last: 1'b1};
          n_res            = 2'd1;
          if (s_tdata == terminator) begin
            r0.run_last = 1'b0;
            r1          = '{byte_val: 8'd0, token_end: 1'b1, run_last: 1'b1};
            n_res       = 2'd2;
          end else if (s_tdata == CH_BSLASH) begin
            mode_next = MODE_ESC;
          end else begin
            r0.run_last = 1'b0;
            r1          = '{byte_val: s_tdata, token_end: 1'b0, run_last: 1'b1};
            n_res       = 2'd2;
          end
        end
      end
      default: begin
        // plain text, also any unused mode code
        mode_next = MODE_PLAIN;
        if (s_tdata == terminator) begin
          n_res = 2'd1;
          r0    = '{byte_val: 8'd0, token_end: 1'b1, run_last: 1'b1};
        end else if (s_tdata == CH_BSLASH) begin
          mode_next = MODE_ESC;
        end else begin
          n_res = 2'd1;
          r0    = '{byte_val: s_tdata, token_end: 1'b0, run_last: 1'b1};
        end
      end
    endcase
  end

  // decode state advances only on an accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_PLAIN;
      octal_value <= '0;
      octal_count <= '0;
    end else if (in_acc) begin
      mode        <= mode_next;
      octal_value <= octal_value_next;
      octal_count <= octal_count_next;
    end
  end

  // queue payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc && n_res != 2'd0) begin
      q[tail] <= r0;
    end
    if (in_acc && n_res == 2'd2) begin
      q[tail + QPTR_W'(1)] <= r1;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (in_acc) begin
        tail <= tail + QPTR_W'(n_res);
      end
      if (out_acc) begin
        head <= head + QPTR_W'(1);
      end
      count <= count + (in_acc ? QCNT_W'(n_res) : QCNT_W'(0))
                     - (out_acc ? QCNT_W'(1) : QCNT_W'(0));
    end
  end

  assign m_tvalid = (count != '0);
  assign m_tdata  = q[head].byte_val;
  assign m_tuser  = q[head].token_end;
  assign m_tlast  = q[head].run_last;

  // queue never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  // digit collection holds one or two digits
  a_digit_count: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_DIGITS |-> (octal_count == 2'd1 || octal_count == 2'd2))
    else $error("bad digit count while collecting");

  // outside digit collection the digit state is clear
  a_digit_clear: assert property (@(posedge clk) disable iff (rst)
    mode != MODE_DIGITS |-> (octal_count == 2'd0 && octal_value == 8'd0))
    else $error("stale digit state");

  // a token end is always the last result of its beat and carries no byte
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tlast && m_tdata == 8'd0))
    else $error("token end not last or carries data");

  // caret consumes exactly one byte
  a_caret_once: assert property (@(posedge clk) disable iff (rst)
    in_acc && mode == MODE_CARET |=> mode == MODE_PLAIN)
    else $error("caret escape did not return to plain");

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import qsed_pkg::*;

  // cycles with no beat on any channel before the run is declared hung
  localparam int WD_LIMIT = 500;
  // cycles allowed after the last decoded beat for stray results to show up
  localparam int DRAIN_CYCLES = 10;
  localparam int DIR_N = 28;

  localparam res_t NO_RES = '0;

  // escape letters that the decoder translates, plus quote, apostrophe, backslash
  localparam logic [7:0] ESC_KEYS [18] = '{
    "r", "n", "f", "t", "b", "v", "R", "N", "F", "T", "B", "V",
    "e", "E", "?", "\"", "'", "\\"
  };

  // one stimulus row: the body byte and, for typed rows, the results read off by hand
  typedef struct packed {
    logic       typed;
    logic [1:0] cnt;
    logic [7:0] inb;
    res_t       r0;
    res_t       r1;
  } row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = '0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       m_tuser;

  // row currently on the slave side, registered together with s_tdata
  row_t pres_row = '0;

  // decoder state mirrored by the testbench
  mode_t      dec_mode;
  logic [7:0] oct_val;
  logic [1:0] oct_cnt;
  logic [7:0] term_reg;

  res_t pending_results [$];
  row_t dir_rows [DIR_N];
  logic [7:0] cur_term = TERM_RESET;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int err_cnt = 0;
  int bytes_in = 0;
  int results_out = 0;
  int wd_cnt = 0;

  quoted_string_escape_decoder_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  // 10 ns clock, low half first so that the first rising edge is at 5 ns
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic res_t mk_res(input logic [7:0] b, input logic e, input logic l);
    res_t r;
    r.byte_val  = b;
    r.token_end = e;
    r.run_last  = l;
    return r;
  endfunction

  // row checked against the predictor
  function automatic row_t chk(input logic [7:0] b);
    return {1'b0, 2'd0, b, NO_RES, NO_RES};
  endfunction

  // row with one result typed in by hand
  function automatic row_t typed1(input logic [7:0] b, input res_t r);
    return {1'b1, 2'd1, b, r, NO_RES};
  endfunction

  function automatic logic [7:0] esc_xlate(input logic [7:0] c);
    case (c)
      "r", "R": return 8'd13;
      "n", "N": return 8'd10;
      "f", "F": return 8'd12;
      "t", "T": return 8'd9;
      "b", "B": return 8'd8;
      "v", "V": return 8'd11;
      "e", "E": return 8'd27;
      "?":      return 8'd127;
      default:  return c;  // quote, apostrophe, backslash and the rest map to themselves
    endcase
  endfunction

  // decodes one body byte against the mirrored state, returns the number of results
  function automatic int decode_byte(input logic [7:0] c, output res_t r0, output res_t r1);
    res_t       rs [2];
    int         n;
    logic       dig;
    logic       as_plain;
    logic [1:0] cnt_nx;
    n = 0;
    rs[0] = NO_RES;
    rs[1] = NO_RES;
    dig = (c >= CH_ZERO) && (c <= CH_NINE);
    as_plain = 1'b0;
    case (dec_mode)
      MODE_ESC: begin
        if (dig) begin
          oct_val = c - CH_ZERO;
          oct_cnt = 2'd1;
          dec_mode = MODE_DIGITS;
        end else if (c == CH_CARET) begin
          dec_mode = MODE_CARET;
        end else begin
          dec_mode = MODE_PLAIN;
          rs[n] = mk_res(esc_xlate(c), 1'b0, 1'b0);
          n++;
        end
      end
      MODE_CARET: begin
        dec_mode = MODE_PLAIN;
        rs[n] = mk_res(c & CTRL_MASK, 1'b0, 1'b0);
        n++;
      end
      MODE_DIGITS: begin
        if (dig) begin
          // 8-bit context keeps the value modulo 256
          oct_val = oct_val * 8'd8 + (c - CH_ZERO);
          cnt_nx = oct_cnt + 2'd1;
          oct_cnt = cnt_nx;
          if (cnt_nx >= DIGITS_MAX || cnt_nx == 2'd0) begin
            rs[n] = mk_res(oct_val, 1'b0, 1'b0);
            n++;
            dec_mode = MODE_PLAIN;
            oct_val = '0;
            oct_cnt = '0;
          end
        end else begin
          // short run: flush the value, then treat the byte as plain text
          rs[n] = mk_res(oct_val, 1'b0, 1'b0);
          n++;
          oct_val = '0;
          oct_cnt = '0;
          as_plain = 1'b1;
        end
      end
      default: as_plain = 1'b1;
    endcase
    if (as_plain) begin
      dec_mode = MODE_PLAIN;
      // terminator test first, so a backslash terminator ends the token
      if (c == term_reg) begin
        rs[n] = mk_res(8'h00, 1'b1, 1'b0);
        n++;
      end else if (c == CH_BSLASH) begin
        dec_mode = MODE_ESC;
      end else begin
        rs[n] = mk_res(c, 1'b0, 1'b0);
        n++;
      end
    end
    if (n > 0) rs[n-1].run_last = 1'b1;
    r0 = rs[0];
    r1 = rs[1];
    return n;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    err_cnt++;
    if (err_cnt <= 40)
      $display("mismatch at result %0d: %s got 0x%0h want 0x%0h", results_out, what, got, want);
  endtask

  // receiver: random stall per cycle, one assignment per edge
  always @(posedge clk) begin
    m_tready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: predicts on every accepted body beat, checks every decoded beat,
  // tracks terminator writes and watches for a hang
  always @(posedge clk) begin
    int   n;
    res_t r0, r1, got, want;
    logic moved;
    if (rst) begin
      dec_mode = MODE_PLAIN;
      oct_val  = '0;
      oct_cnt  = '0;
      term_reg = TERM_RESET;
      wd_cnt   = 0;
    end else begin
      moved = 1'b0;
      if (s_tvalid && s_tready) begin
        n = decode_byte(pres_row.inb, r0, r1);
        // typed rows replace the predicted results, the state still advances
        if (pres_row.typed) begin
          n  = int'(pres_row.cnt);
          r0 = pres_row.r0;
          r1 = pres_row.r1;
        end
        if (n > 0) pending_results.push_back(r0);
        if (n > 1) pending_results.push_back(r1);
        bytes_in++;
        moved = 1'b1;
      end
      // a new terminator applies from the next body beat on
      if (cfg_valid && cfg_ready) begin
        term_reg = cfg_data;
        moved = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        got = mk_res(m_tdata, m_tuser, m_tlast);
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending, out_byte", int'(got.byte_val), 0);
        end else begin
          want = pending_results.pop_front();
          if (got.byte_val !== want.byte_val)
            report_mismatch("out_byte", int'(got.byte_val), int'(want.byte_val));
          if (got.token_end !== want.token_end)
            report_mismatch("token_end", int'(got.token_end), int'(want.token_end));
          if (got.run_last !== want.run_last)
            report_mismatch("run_last", int'(got.run_last), int'(want.run_last));
        end
        results_out++;
        moved = 1'b1;
      end
      wd_cnt = moved ? 0 : wd_cnt + 1;
      if (wd_cnt >= WD_LIMIT) begin
        $display("hang: no beat for %0d cycles, %0d results pending", wd_cnt,
                 pending_results.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // present one body beat, with random idle cycles ahead of it
  task automatic send_row(input row_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= row.inb;
    pres_row <= row;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // terminator write, only with the decoder idle and nothing pending
  task automatic write_term(input logic [7:0] v);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_term = v;
  endtask

  // one random fragment of a string body, mostly well-formed escapes
  task automatic send_chunk(inout int sent);
    logic [7:0] seq [$];
    int kind;
    int nd;
    kind = $urandom_range(99);
    if (kind < 28) begin
      seq.push_back(8'($urandom_range(8'h7e, 8'h20)));
    end else if (kind < 40) begin
      // noise over the whole byte range
      seq.push_back(8'($urandom_range(255)));
    end else if (kind < 50) begin
      seq.push_back(cur_term);
    end else if (kind < 65) begin
      seq.push_back(CH_BSLASH);
      if ($urandom_range(3) != 0) seq.push_back(ESC_KEYS[$urandom_range(17)]);
      else seq.push_back(8'($urandom_range(255)));
    end else if (kind < 73) begin
      // caret control escape over any byte
      seq.push_back(CH_BSLASH);
      seq.push_back(CH_CARET);
      seq.push_back(8'($urandom_range(255)));
    end else if (kind < 93) begin
      // digit run, a short one is closed by plain text, a terminator or a new escape
      seq.push_back(CH_BSLASH);
      nd = $urandom_range(3, 1);
      repeat (nd) seq.push_back(CH_ZERO + 8'($urandom_range(9)));
      if (nd < 3) begin
        case ($urandom_range(2))
          0: seq.push_back(8'($urandom_range(8'h7e, 8'h20)));
          1: seq.push_back(cur_term);
          default: seq.push_back(CH_BSLASH);
        endcase
      end
    end else begin
      // escaped terminator or escaped backslash
      seq.push_back(CH_BSLASH);
      seq.push_back($urandom_range(1) ? cur_term : CH_BSLASH);
    end
    foreach (seq[i]) send_row(chk(seq[i]));
    sent += seq.size();
  endtask

  task automatic run_phase(input logic [7:0] term, input int n_items, input int s_pct,
                           input int r_pct);
    int sent;
    write_term(term);
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    sent = 0;
    while (sent < n_items) send_chunk(sent);
    s_tvalid <= 1'b0;
  endtask

  initial begin
    // directed rows, terminator at its reset value (double quote)
    dir_rows = '{
      typed1(8'h41, mk_res(8'h41, 1'b0, 1'b1)),   // plain byte right after reset
      typed1(8'h00, mk_res(8'h00, 1'b0, 1'b1)),   // lowest byte
      typed1(8'hff, mk_res(8'hff, 1'b0, 1'b1)),   // highest byte
      {1'b1, 2'd0, CH_BSLASH, NO_RES, NO_RES},    // backslash alone gives nothing
      chk("n"),
      chk(CH_BSLASH), chk("?"),
      chk(CH_BSLASH), chk("\""),                  // escaped terminator passes through
      chk(CH_BSLASH), chk(CH_CARET),
      typed1(8'hff, mk_res(8'h1f, 1'b0, 1'b1)),   // caret over the top byte
      chk(CH_BSLASH), chk("9"), chk("9"),
      typed1("9", mk_res(8'h91, 1'b0, 1'b1)),     // three nines wrap modulo 256
      chk(CH_BSLASH), chk("7"), chk("\""),        // short run closed by the terminator
      chk(CH_BSLASH), chk("4"), chk("2"), chk("x"),
      chk(CH_BSLASH), chk("5"), chk(CH_BSLASH), chk("t"),  // short run closed by escape
      typed1("\"", mk_res(8'h00, 1'b1, 1'b1))     // bare terminator ends the token
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct  = 17;
    recv_stall_pct = 50;
    foreach (dir_rows[i]) send_row(dir_rows[i]);
    s_tvalid <= 1'b0;

    // random body: sender idles lightly, receiver stalls half the time
    run_phase(8'hff, 170, 17, 50);
    // backslash as terminator: an unescaped backslash ends the token
    run_phase(CH_BSLASH, 170, 50, 17);
    // no idling on either side from here on
    run_phase(8'h00, 110, 0, 0);
    // a digit as terminator clashes with digit runs
    run_phase("7", 100, 0, 0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d body beats and %0d decoded beats over five terminator settings,",
             bytes_in, results_out);
    $display("with escapes, caret controls and digit runs under both stall patterns");
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/qsed_pkg.sv
hw/rtl/quoted_string_escape_decoder_top.sv
test/tb_top.sv
